// ===== rtl/ssqi_pkg.sv =====
// Package for the segment / square intersection block.
// Widths, pipeline depth and the control and status structs shared by
// ssqi_pipe and segment_square_intersect_top. No dependencies.
package ssqi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NStage = 5;

  // Control into the datapath.
  typedef struct packed {
    logic adv;
    logic in_vld;
  } sqi_ctrl_t;

  // Status out of the datapath.
  typedef struct packed {
    logic [NStage-1:0] vld;
    logic              hit;
  } sqi_stat_t;

endpackage

// ===== rtl/ssqi_pipe.sv =====
// Five-stage arithmetic pipeline for the segment / square intersection test.
// Depends on ssqi_pkg for widths and the control/status structs.
module ssqi_pipe import ssqi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sqi_ctrl_t                ctrl_i,
  input  logic        [TolW-1:0]   tol_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] end_z_i,
  output sqi_stat_t                stat_o
);

  localparam int unsigned DW = CoordW + 1;        // differences
  localparam int unsigned PW = CoordW + DW;       // products
  localparam int unsigned XW = PW + 1;            // crossing numerators
  localparam int unsigned KW = DW + FracW;        // d scaled to Q16
  localparam int unsigned TW = TolW + DW;         // tol * d
  localparam int unsigned CW = KW + 3;            // t bound checks
  localparam int unsigned WW = XW + 4;            // final compares

  function automatic logic in_bounds(input logic signed [WW-1:0] w,
                                     input logic signed [WW-1:0] lo,
                                     input logic signed [WW-1:0] hi);
    logic signed [WW-1:0] s_lo;
    logic signed [WW-1:0] s_hi;
    s_lo = w + lo;
    s_hi = hi - w;
    return !s_lo[WW-1] && !s_hi[WW-1];
  endfunction

  logic [NStage-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl_i.adv) begin
      vld_q <= {vld_q[NStage-2:0], ctrl_i.in_vld};
    end
  end

  // Stage 1: differences, |dz|, signed t numerator
  logic signed [CoordW-1:0] ax1_q, ay1_q, az1_q;
  logic signed [DW-1:0]     dx1_d, dy1_d, dz1_d, dx1_q, dy1_q, dz1_q, tn1_d, tn1_q;
  logic        [DW-1:0]     d1_d, d1_q;
  logic                     neg1_d, neg1_q, zero1_d, zero1_q;

  always_comb begin
    dx1_d   = DW'(start_x_i) - DW'(end_x_i);
    dy1_d   = DW'(start_y_i) - DW'(end_y_i);
    dz1_d   = DW'(start_z_i) - DW'(end_z_i);
    neg1_d  = dz1_d[DW-1];
    zero1_d = (dz1_d == '0);
    d1_d    = neg1_d ? DW'(-dz1_d) : DW'(dz1_d);
    tn1_d   = neg1_d ? -DW'(start_z_i) : DW'(start_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      ax1_q   <= start_x_i;
      ay1_q   <= start_y_i;
      az1_q   <= start_z_i;
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      dz1_q   <= dz1_d;
      d1_q    <= d1_d;
      tn1_q   <= tn1_d;
      neg1_q  <= neg1_d;
      zero1_q <= zero1_d;
    end
  end

  // Stage 2: products
  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic        [TW-1:0] tdp2_q;
  logic        [DW-1:0] d2_q;
  logic signed [DW-1:0] tn2_q;
  logic                 neg2_q, zero2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      m0_q    <= PW'(ax1_q) * PW'(dz1_q);
      m1_q    <= PW'(az1_q) * PW'(dx1_q);
      m2_q    <= PW'(ay1_q) * PW'(dz1_q);
      m3_q    <= PW'(az1_q) * PW'(dy1_q);
      tdp2_q  <= TW'(tol_i) * TW'(d1_q);
      d2_q    <= d1_q;
      tn2_q   <= tn1_q;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
    end
  end

  // Stage 3: crossing point numerators, bounds, t range check
  logic signed [XW-1:0] px3_d, py3_d, px3_q, py3_q;
  logic        [KW-1:0] kd3_d, kd3_q;
  logic        [TW:0]   lo3_d, lo3_q;
  logic        [TW+1:0] hi3_d, hi3_q;
  logic        [TW:0]   ksum3;
  logic signed [CW-1:0] tn16, tlo3, thi3;
  logic                 ok3_d, ok3_q;

  always_comb begin
    px3_d = neg2_q ? XW'(m1_q) - XW'(m0_q) : XW'(m0_q) - XW'(m1_q);
    py3_d = neg2_q ? XW'(m3_q) - XW'(m2_q) : XW'(m2_q) - XW'(m3_q);
    kd3_d = {d2_q, {FracW{1'b0}}};
    ksum3 = (TW+1)'(kd3_d) + (TW+1)'(tdp2_q);
    lo3_d = {tdp2_q, 1'b0};
    hi3_d = {ksum3, 1'b0};
    tn16  = {{(CW-KW){tn2_q[DW-1]}}, tn2_q, {FracW{1'b0}}};
    tlo3  = tn16 + $signed(CW'(tdp2_q));
    thi3  = $signed(CW'(ksum3)) - tn16;
    ok3_d = !tlo3[CW-1] && !thi3[CW-1] && !zero2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      px3_q <= px3_d;
      py3_q <= py3_d;
      kd3_q <= kd3_d;
      lo3_q <= lo3_d;
      hi3_q <= hi3_d;
      ok3_q <= ok3_d;
    end
  end

  // Stage 4: barycentric numerators
  logic signed [WW-1:0] pxw, pyw, kdw;
  logic signed [WW-1:0] wa4_q, wb4_q, wc4_q, we4_q, lo4_q, hi4_q;
  logic                 ok4_q;

  always_comb begin
    pxw = WW'(px3_q);
    pyw = WW'(py3_q);
    kdw = $signed(WW'(kd3_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      wa4_q <= kdw - pyw;
      wb4_q <= pyw - pxw;
      wc4_q <= kdw - pxw;
      we4_q <= pxw - pyw;
      lo4_q <= $signed(WW'(lo3_q));
      hi4_q <= $signed(WW'(hi3_q));
      ok4_q <= ok3_q;
    end
  end

  // Stage 5: range checks, result register
  logic signed [WW-1:0] sa5, sc5;
  logic                 tri_a, tri_b, hit5_q;

  always_comb begin
    sa5   = hi4_q - wa4_q;
    sc5   = hi4_q - wc4_q;
    tri_a = in_bounds(wa4_q, lo4_q, hi4_q) && in_bounds(wb4_q, lo4_q, hi4_q) && !sc5[WW-1];
    tri_b = in_bounds(wc4_q, lo4_q, hi4_q) && in_bounds(we4_q, lo4_q, hi4_q) && !sa5[WW-1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      hit5_q <= ok4_q && (tri_a || tri_b);
    end
  end

  assign stat_o.vld = vld_q;
  assign stat_o.hit = hit5_q;

endmodule

// ===== rtl/segment_square_intersect_top.sv =====
// Segment versus square [-1,1]x[-1,1] in z=0, top level.
// Holds the tolerance register and the pipeline handshake; uses ssqi_pkg
// and ssqi_pipe.
//
// Input channel: in_valid_i / in_stall_o with the six Q16.16 coordinates.
// Output channel: out_valid_o / out_stall_i with hit_o.
// A transfer happens on a rising edge where valid is high and stall low.
// Config channel: cfg_valid_i / cfg_ready_o writes edge_tolerance_i (Q0.16);
// cfg_ready_o is always high, write only while no item is in flight.
// An input transfer reaches out_valid_o through the five pipeline registers;
// one item per cycle is taken while the pipe is not frozen (see below).
// When the receiver stalls with a result pending the whole pipe freezes and
// in_stall_o is raised; nothing is lost or repeated.
// Reset empties the pipe and clears the tolerance to zero.
module segment_square_intersect_top import ssqi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] end_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic        [TolW-1:0]   edge_tolerance_i
);

  logic [TolW-1:0] tol_q;
  sqi_ctrl_t       ctrl;
  sqi_stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= edge_tolerance_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign ctrl.adv    = !(stat.vld[NStage-1] && out_stall_i);
  assign ctrl.in_vld = in_valid_i;

  ssqi_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .tol_i     (tol_q),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .end_z_i   (end_z_i),
    .stat_o    (stat)
  );

  assign in_stall_o  = !ctrl.adv;
  assign out_valid_o = stat.vld[NStage-1];
  assign hit_o       = stat.hit;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> stat.vld[0])
    else $error("accepted item missing from first stage");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(stat.vld))
    else $error("pipe occupancy changed while frozen");

  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> stat.vld[NStage-1:1] == $past(stat.vld[NStage-2:0]))
    else $error("valid bits did not move with the data");

endmodule
